// ===== design/rocpc_pkg.sv =====
// Shared constants, field positions, types and a helper function for the ROC point counter.
// Depends on nothing; the divider, the top level and the checker refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package rocpc_pkg;

   localparam int MAX_THRESHOLDS = 64;
   localparam int COUNT_WIDTH    = 32;
   localparam int FRACTION_BITS  = 16;

   localparam int FRAC_W  = FRACTION_BITS + 1;
   localparam int ADDR_W  = (MAX_THRESHOLDS > 1) ? $clog2(MAX_THRESHOLDS) : 1;
   localparam int CMD_W   = 2;
   localparam int ENTRY_W = 6;
   localparam int LABEL_W = 8;
   localparam int USE_W   = 7;
   // Wide enough for an entry index, the use count and the table depth itself.
   localparam int IDX_W   = ($clog2(MAX_THRESHOLDS + 1) > USE_W) ?
                            $clog2(MAX_THRESHOLDS + 1) : USE_W;
   localparam int STEP_W  = $clog2(FRACTION_BITS + 1);

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_LOAD   = 2'd1,
      CMD_SAMPLE = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_NEGATIVE_LABEL    = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLDS_IN_USE = 8'd1;
   localparam logic [USE_W-1:0]       THRESHOLDS_RESET      = 7'd64;

   // Request tdata layout, lowest bit first.
   localparam int REQ_ENTRY_LSB  = 0;
   localparam int REQ_FRAC_LSB   = REQ_ENTRY_LSB + ENTRY_W;
   localparam int REQ_LABEL_LSB  = REQ_FRAC_LSB + FRAC_W;
   localparam int REQ_FIELD_BITS = REQ_LABEL_LSB + LABEL_W;
   localparam int REQ_DATA_W     = ((REQ_FIELD_BITS + 7) / 8) * 8;

   // Response tdata layout, lowest bit first.
   localparam int RSP_INDEX_LSB  = 0;
   localparam int RSP_TPC_LSB    = RSP_INDEX_LSB + ENTRY_W;
   localparam int RSP_FPC_LSB    = RSP_TPC_LSB + COUNT_WIDTH;
   localparam int RSP_POS_LSB    = RSP_FPC_LSB + COUNT_WIDTH;
   localparam int RSP_NEG_LSB    = RSP_POS_LSB + COUNT_WIDTH;
   localparam int RSP_TPR_LSB    = RSP_NEG_LSB + COUNT_WIDTH;
   localparam int RSP_FPR_LSB    = RSP_TPR_LSB + FRAC_W;
   localparam int RSP_TPU_BIT    = RSP_FPR_LSB + FRAC_W;
   localparam int RSP_FPU_BIT    = RSP_TPU_BIT + 1;
   localparam int RSP_FIELD_BITS = RSP_FPU_BIT + 1;
   localparam int RSP_DATA_W     = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [FRAC_W-1:0]      FRAC_ONE  = {1'b1, {FRACTION_BITS{1'b0}}};

   typedef struct packed {
      logic done;
      logic undefined;
   } div_status_type;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
      return (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
   endfunction

endpackage

`default_nettype wire

// ===== design/rocpc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Stands alone; used for the threshold table and the counter store.
`timescale 1ns / 1ps
`default_nettype none

module rocpc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   we,
   input  wire logic [ADDR_BITS-1:0]   waddr,
   input  wire logic [WIDTH-1:0]       wdata,
   input  wire logic [ADDR_BITS-1:0]   raddr,
   output logic      [WIDTH-1:0]       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== design/rocpc_rate_div.sv =====
// Restoring divider that forms count / total in fixed point, one quotient bit per cycle.
// Depends on rocpc_pkg for widths, the value one and the status struct.
`timescale 1ns / 1ps
`default_nettype none

module rocpc_rate_div (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [rocpc_pkg::COUNT_WIDTH-1:0]   numerator,
   input  wire logic [rocpc_pkg::COUNT_WIDTH-1:0]   denominator,
   output logic      [rocpc_pkg::FRAC_W-1:0]        quotient,
   output rocpc_pkg::div_status_type                status
);

   localparam int W = rocpc_pkg::COUNT_WIDTH;
   localparam int F = rocpc_pkg::FRACTION_BITS;

   logic [W-1:0]                   rem_ff, rem_in;
   logic [W-1:0]                   den_ff, den_in;
   logic [F-1:0]                   q_ff, q_in;
   logic [rocpc_pkg::STEP_W-1:0]   step_ff, step_in;
   logic                           over_ff, over_in;
   logic                           zero_ff, zero_in;
   logic                           done_ff, done_in;
   logic [W:0]                     shifted;
   logic [W:0]                     diff;
   logic                           fits;

   always_comb begin
      shifted = {rem_ff, 1'b0};
      diff    = shifted - {1'b0, den_ff};
      fits    = (shifted >= {1'b0, den_ff});
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      step_in = step_ff;
      over_in = over_ff;
      zero_in = zero_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = numerator;
         den_in  = denominator;
         q_in    = '0;
         step_in = rocpc_pkg::STEP_W'(F);
         over_in = (numerator >= denominator);
         zero_in = (denominator == '0);
         done_in = 1'b0;
      end else if (step_ff != '0) begin
         rem_in  = fits ? diff[W-1:0] : shifted[W-1:0];
         q_in    = {q_ff[F-2:0], fits};
         step_in = step_ff - 1'b1;
         done_in = (step_ff == rocpc_pkg::STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      q_ff    <= q_in;
      over_ff <= over_in;
      zero_ff <= zero_in;
   end

   // A zero total gives a rate of zero; a count at or above the total gives one.
   assign quotient = zero_ff ? '0 : (over_ff ? rocpc_pkg::FRAC_ONE : {1'b0, q_ff});
   assign status.done      = done_ff;
   assign status.undefined = zero_ff;

endmodule

`default_nettype wire

// ===== design/roc_point_counter_top.sv =====
// Top level of the ROC point counter: command decode, table sweep, totals and read path.
// Depends on rocpc_pkg, rocpc_ram (threshold table, counter store) and rocpc_rate_div.
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Beat contents
// ---------+-----------+--------------------------------------------------------------
// req_     | in        | tuser: command; tdata: entry index, fraction, class label
// rsp_     | out       | tdata: index, TP, FP, totals, TP/FP rates, undefined flags
// csr_     | in        | index 0 negative label, index 1 thresholds in use
//
// Clear and load are done without leaving the idle state. A sample sweeps the counter
// store over the entries in use (capped at the table depth) one entry per cycle through
// its single read port, with the write-back in the cycle after the read.
// A read does one store read, then runs both one-bit-a-step dividers.
// Synchronous active-high reset clears control state, the totals and the per-entry
// valid bits, so every table entry and counter reads as zero; there is no clearing pass.
// A result waiting on rsp_tready does not stop the block taking clear, load or sample
// beats; a following read only stalls at its end until the output register is free.

module roc_point_counter_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // Request channel.
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // tdata: entry_index, fraction_value, class_label (lowest bit first), zero padding.
   input  wire logic [rocpc_pkg::REQ_DATA_W-1:0]      req_tdata,
   // tuser: command.
   input  wire logic [rocpc_pkg::CMD_W-1:0]           req_tuser,
   // Response channel.
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // tdata: point_index, true_positive_count, false_positive_count, positive_total,
   // negative_total, true_positive_rate, false_positive_rate, tp_rate_undefined,
   // fp_rate_undefined (lowest bit first), zero padding.
   output logic      [rocpc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // Configuration write channel.
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [rocpc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [rocpc_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int CW = rocpc_pkg::COUNT_WIDTH;
   localparam int FW = rocpc_pkg::FRAC_W;
   localparam int AW = rocpc_pkg::ADDR_W;
   localparam int NT = rocpc_pkg::MAX_THRESHOLDS;
   localparam int XW = rocpc_pkg::IDX_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_READ,
      ST_DIV
   } state_type;

   state_type                          state_ff, state_in;
   logic [rocpc_pkg::LABEL_W-1:0]      neg_label_ff, neg_label_in;
   logic [rocpc_pkg::USE_W-1:0]        in_use_ff, in_use_in;
   logic [CW-1:0]                      pos_total_ff, pos_total_in;
   logic [CW-1:0]                      neg_total_ff, neg_total_in;
   logic [NT-1:0]                      thr_vld_ff, thr_vld_in;
   logic [NT-1:0]                      cnt_vld_ff, cnt_vld_in;
   logic [XW-1:0]                      idx_ff, idx_in;
   logic [XW-1:0]                      used_ff, used_in;
   logic                               s1_valid_ff, s1_valid_in;
   logic [AW-1:0]                      s1_addr_ff;
   logic                               thr_hit_ff, cnt_hit_ff;
   logic                               pos_ff, pos_in;
   logic [FW-1:0]                      score_ff, score_in;
   logic [rocpc_pkg::ENTRY_W-1:0]      rd_entry_ff, rd_entry_in;
   logic                               rd_in_table_ff, rd_in_table_in;
   logic [CW-1:0]                      rd_tp_ff, rd_tp_in;
   logic [CW-1:0]                      rd_fp_ff, rd_fp_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [rocpc_pkg::RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   rocpc_pkg::cmd_type                 cmd;
   logic [rocpc_pkg::ENTRY_W-1:0]      req_entry;
   logic [FW-1:0]                      req_frac;
   logic [rocpc_pkg::LABEL_W-1:0]      req_label;
   logic [XW-1:0]                      entry_ext;
   logic                               entry_in_table;
   logic                               accept;
   logic [XW-1:0]                      in_use_ext;
   logic                               rd_en;
   logic [AW-1:0]                      raddr;

   logic                               thr_we;
   logic [FW-1:0]                      thr_rdata;
   logic                               cnt_we;
   logic [2*CW-1:0]                    cnt_wdata;
   logic [2*CW-1:0]                    cnt_rdata;
   logic [FW-1:0]                      thr_val;
   logic [CW-1:0]                      base_tp, base_fp;
   logic                               hit;
   logic                               div_start;
   logic [FW-1:0]                      tp_rate, fp_rate;
   rocpc_pkg::div_status_type          tp_status, fp_status;

   assign cmd       = rocpc_pkg::cmd_type'(req_tuser);
   assign req_entry = req_tdata[rocpc_pkg::REQ_ENTRY_LSB +: rocpc_pkg::ENTRY_W];
   assign req_frac  = req_tdata[rocpc_pkg::REQ_FRAC_LSB +: FW];
   assign req_label = req_tdata[rocpc_pkg::REQ_LABEL_LSB +: rocpc_pkg::LABEL_W];
   assign entry_ext      = XW'(req_entry);
   assign entry_in_table = (entry_ext < XW'(NT));
   assign in_use_ext     = XW'(in_use_ff);

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // The sweep walks entries from zero up to the clamped use count.
   assign rd_en = (state_ff == ST_SWEEP) && (idx_ff < used_ff);
   assign raddr = (state_ff == ST_SWEEP) ? idx_ff[AW-1:0] : entry_ext[AW-1:0];

   // Entries never loaded or cleared since reset read as zero through their valid bits.
   assign thr_val = thr_hit_ff ? thr_rdata : '0;
   assign base_tp = cnt_hit_ff ? cnt_rdata[CW-1:0] : '0;
   assign base_fp = cnt_hit_ff ? cnt_rdata[2*CW-1:CW] : '0;
   assign hit     = s1_valid_ff && (thr_val <= score_ff);
   assign cnt_we  = hit;
   assign cnt_wdata = pos_ff ? {base_fp, rocpc_pkg::sat_inc(base_tp)}
                             : {rocpc_pkg::sat_inc(base_fp), base_tp};
   assign thr_we    = accept && (cmd == rocpc_pkg::CMD_LOAD) && entry_in_table;
   assign div_start = (state_ff == ST_READ);

   rocpc_ram #(
      .WIDTH (FW),
      .DEPTH (NT)
   ) u_thr_ram (
      .clock (clock),
      .we    (thr_we),
      .waddr (entry_ext[AW-1:0]),
      .wdata (req_frac),
      .raddr (raddr),
      .rdata (thr_rdata)
   );

   // Counter store: false-positive count in the upper half, true-positive in the lower.
   rocpc_ram #(
      .WIDTH (2 * CW),
      .DEPTH (NT)
   ) u_cnt_ram (
      .clock (clock),
      .we    (cnt_we),
      .waddr (s1_addr_ff),
      .wdata (cnt_wdata),
      .raddr (raddr),
      .rdata (cnt_rdata)
   );

   rocpc_rate_div u_tp_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (rd_tp_in),
      .denominator (pos_total_ff),
      .quotient    (tp_rate),
      .status      (tp_status)
   );

   rocpc_rate_div u_fp_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (rd_fp_in),
      .denominator (neg_total_ff),
      .quotient    (fp_rate),
      .status      (fp_status)
   );

   always_comb begin
      state_in       = state_ff;
      neg_label_in   = neg_label_ff;
      in_use_in      = in_use_ff;
      pos_total_in   = pos_total_ff;
      neg_total_in   = neg_total_ff;
      thr_vld_in     = thr_vld_ff;
      cnt_vld_in     = cnt_vld_ff;
      idx_in         = idx_ff;
      used_in        = used_ff;
      s1_valid_in    = rd_en;
      pos_in         = pos_ff;
      score_in       = score_ff;
      rd_entry_in    = rd_entry_ff;
      rd_in_table_in = rd_in_table_ff;
      rd_tp_in       = rd_tp_ff;
      rd_fp_in       = rd_fp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;

      if (csr_valid && csr_ready) begin
         if (csr_index == rocpc_pkg::CSR_NEGATIVE_LABEL) begin
            neg_label_in = csr_data[rocpc_pkg::LABEL_W-1:0];
         end else if (csr_index == rocpc_pkg::CSR_THRESHOLDS_IN_USE) begin
            in_use_in = csr_data[rocpc_pkg::USE_W-1:0];
         end
      end

      // Write-back stage of the sweep marks the entry as holding real counts.
      if (hit) begin
         cnt_vld_in[s1_addr_ff] = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (cmd)
                  rocpc_pkg::CMD_CLEAR: begin
                     cnt_vld_in   = '0;
                     pos_total_in = '0;
                     neg_total_in = '0;
                  end
                  rocpc_pkg::CMD_LOAD: begin
                     if (entry_in_table) begin
                        thr_vld_in[entry_ext[AW-1:0]] = 1'b1;
                     end
                  end
                  rocpc_pkg::CMD_SAMPLE: begin
                     pos_in   = (req_label != neg_label_ff);
                     score_in = req_frac;
                     idx_in   = '0;
                     used_in  = (in_use_ext > XW'(NT)) ? XW'(NT) : in_use_ext;
                     if (req_label != neg_label_ff) begin
                        pos_total_in = rocpc_pkg::sat_inc(pos_total_ff);
                     end else begin
                        neg_total_in = rocpc_pkg::sat_inc(neg_total_ff);
                     end
                     state_in = ST_SWEEP;
                  end
                  rocpc_pkg::CMD_READ: begin
                     rd_entry_in    = req_entry;
                     rd_in_table_in = entry_in_table;
                     state_in       = ST_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            if (rd_en) begin
               idx_in = idx_ff + 1'b1;
            end else if (!s1_valid_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            rd_tp_in = (cnt_hit_ff && rd_in_table_ff) ? cnt_rdata[CW-1:0] : '0;
            rd_fp_in = (cnt_hit_ff && rd_in_table_ff) ? cnt_rdata[2*CW-1:CW] : '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (tp_status.done && fp_status.done && (!rsp_valid_ff || rsp_tready)) begin
               rsp_data_in = '0;
               rsp_data_in[rocpc_pkg::RSP_INDEX_LSB +: rocpc_pkg::ENTRY_W] = rd_entry_ff;
               rsp_data_in[rocpc_pkg::RSP_TPC_LSB +: CW] = rd_tp_ff;
               rsp_data_in[rocpc_pkg::RSP_FPC_LSB +: CW] = rd_fp_ff;
               rsp_data_in[rocpc_pkg::RSP_POS_LSB +: CW] = pos_total_ff;
               rsp_data_in[rocpc_pkg::RSP_NEG_LSB +: CW] = neg_total_ff;
               rsp_data_in[rocpc_pkg::RSP_TPR_LSB +: FW] = tp_rate;
               rsp_data_in[rocpc_pkg::RSP_FPR_LSB +: FW] = fp_rate;
               rsp_data_in[rocpc_pkg::RSP_TPU_BIT]       = tp_status.undefined;
               rsp_data_in[rocpc_pkg::RSP_FPU_BIT]       = fp_status.undefined;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         neg_label_ff <= '0;
         in_use_ff    <= rocpc_pkg::THRESHOLDS_RESET;
         pos_total_ff <= '0;
         neg_total_ff <= '0;
         thr_vld_ff   <= '0;
         cnt_vld_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         neg_label_ff <= neg_label_in;
         in_use_ff    <= in_use_in;
         pos_total_ff <= pos_total_in;
         neg_total_ff <= neg_total_in;
         thr_vld_ff   <= thr_vld_in;
         cnt_vld_ff   <= cnt_vld_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff         <= idx_in;
      used_ff        <= used_in;
      s1_addr_ff     <= raddr;
      thr_hit_ff     <= thr_vld_ff[raddr];
      cnt_hit_ff     <= cnt_vld_ff[raddr];
      pos_ff         <= pos_in;
      score_ff       <= score_in;
      rd_entry_ff    <= rd_entry_in;
      rd_in_table_ff <= rd_in_table_in;
      rd_tp_ff       <= rd_tp_in;
      rd_fp_ff       <= rd_fp_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== design/rocpc_checker.sv =====
// Port-level checks on the ROC point counter's response channel, bound to the top level.
// Depends on rocpc_pkg for the response field positions.
`timescale 1ns / 1ps
`default_nettype none

module rocpc_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic [rocpc_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int CW = rocpc_pkg::COUNT_WIDTH;
   localparam int FW = rocpc_pkg::FRAC_W;

   logic [CW-1:0] tp_count, fp_count, pos_total, neg_total;
   logic [FW-1:0] tp_rate, fp_rate;
   logic          tp_undef, fp_undef;

   assign tp_count  = rsp_tdata[rocpc_pkg::RSP_TPC_LSB +: CW];
   assign fp_count  = rsp_tdata[rocpc_pkg::RSP_FPC_LSB +: CW];
   assign pos_total = rsp_tdata[rocpc_pkg::RSP_POS_LSB +: CW];
   assign neg_total = rsp_tdata[rocpc_pkg::RSP_NEG_LSB +: CW];
   assign tp_rate   = rsp_tdata[rocpc_pkg::RSP_TPR_LSB +: FW];
   assign fp_rate   = rsp_tdata[rocpc_pkg::RSP_FPR_LSB +: FW];
   assign tp_undef  = rsp_tdata[rocpc_pkg::RSP_TPU_BIT];
   assign fp_undef  = rsp_tdata[rocpc_pkg::RSP_FPU_BIT];

   // A result is never shown in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid straight after reset");

   // A stalled result holds still.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // An entry's counts never exceed the class totals they are drawn from.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (tp_count <= pos_total) && (fp_count <= neg_total))
      else $error("entry count above class total");

   // The undefined flags track an empty class and force the rate to zero.
   a_undef_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (tp_undef == (pos_total == '0)) && (fp_undef == (neg_total == '0))
                     && (!tp_undef || (tp_rate == '0)) && (!fp_undef || (fp_rate == '0)))
      else $error("undefined flag does not match totals");

   // Rates stay within zero to one.
   a_rate_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (tp_rate <= rocpc_pkg::FRAC_ONE) && (fp_rate <= rocpc_pkg::FRAC_ONE))
      else $error("rate above one");

endmodule

bind roc_point_counter_top rocpc_checker u_rocpc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
